// ===== design/drst_pkg.sv =====
package drst_pkg;

   typedef enum logic [2:0] {
      OP_ADD      = 3'd0,
      OP_VALIDATE = 3'd1,
      OP_CLEAR    = 3'd2,
      OP_TAKE     = 3'd3,
      OP_PEEK     = 3'd4,
      OP_QUERY    = 3'd5
   } opcode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic free;
      logic owner_hit;
      logic overlap;
   } match_type;

endpackage

// ===== design/drst_slot_mem.sv =====
module drst_slot_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 98
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/drst_slot_match.sv =====
module drst_slot_match #(
   parameter int OWNER_BITS = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                         slot_used,
   input  logic [OWNER_BITS-1:0]        slot_owner,
   input  logic signed [COORD_BITS-1:0] slot_left,
   input  logic signed [COORD_BITS-1:0] slot_top,
   input  logic signed [COORD_BITS-1:0] slot_right,
   input  logic signed [COORD_BITS-1:0] slot_bottom,
   input  logic [OWNER_BITS-1:0]        req_owner,
   input  logic signed [COORD_BITS-1:0] req_left,
   input  logic signed [COORD_BITS-1:0] req_top,
   input  logic signed [COORD_BITS-1:0] req_right,
   input  logic signed [COORD_BITS-1:0] req_bottom,
   output drst_pkg::match_type          match
);

   import drst_pkg::*;

   logic apart;

   always_comb begin
      apart = (req_right <= slot_left) || (req_left >= slot_right) ||
              (req_bottom <= slot_top) || (req_top >= slot_bottom);
      match.free      = !slot_used;
      match.owner_hit = slot_used && (slot_owner == req_owner);
      match.overlap   = !apart;
   end

endmodule

// ===== design/dirty_rect_slot_table.sv =====
// Dirty rectangle slot table. Each transaction is taken when start is high and
// busy is low, and gives exactly one response, shown for one cycle with
// rsp_valid; the receiver cannot stall it, so it must take every response.
// The slots live in a table memory with a read and a write port, read one slot
// per cycle from slot 0 upward with busy high, up to the last slot or until the
// operation stops early, and the next transaction can be started in the cycle
// after the response. After reset the block clears the used marks of all slots
// with busy high.
module dirty_rect_slot_table #(
   parameter int SLOT_COUNT = 64,
   parameter int OWNER_BITS = 32,
   parameter int COORD_BITS = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [2:0]                   req_opcode,
   input  logic [OWNER_BITS-1:0]        req_owner,
   input  logic signed [COORD_BITS-1:0] req_rect_left,
   input  logic signed [COORD_BITS-1:0] req_rect_top,
   input  logic signed [COORD_BITS-1:0] req_rect_right,
   input  logic signed [COORD_BITS-1:0] req_rect_bottom,
   input  logic                         req_erase_in,
   output logic                         rsp_valid,
   output logic                         rsp_found,
   output logic                         rsp_table_full,
   output logic signed [COORD_BITS-1:0] rsp_out_left,
   output logic signed [COORD_BITS-1:0] rsp_out_top,
   output logic signed [COORD_BITS-1:0] rsp_out_right,
   output logic signed [COORD_BITS-1:0] rsp_out_bottom,
   output logic                         rsp_erase_out
);

   import drst_pkg::*;

   localparam int AW = $clog2(SLOT_COUNT);
   localparam int EW = 2 + OWNER_BITS + 4 * COORD_BITS;
   localparam logic [AW-1:0] LAST = AW'(SLOT_COUNT - 1);

   localparam int B_LO = 0;
   localparam int R_LO = COORD_BITS;
   localparam int T_LO = 2 * COORD_BITS;
   localparam int L_LO = 3 * COORD_BITS;
   localparam int O_LO = 4 * COORD_BITS;
   localparam int E_BIT = O_LO + OWNER_BITS;
   localparam int U_BIT = E_BIT + 1;

   state_type state_ff, state_in;
   logic [AW-1:0] issue_addr_ff, issue_addr_in;
   logic issue_on_ff, issue_on_in;
   logic chk_on_ff, chk_on_in;
   logic [AW-1:0] chk_addr_ff, chk_addr_in;

   opcode_type op_ff, op_in;
   logic [OWNER_BITS-1:0] owner_ff, owner_in;
   logic signed [COORD_BITS-1:0] left_ff, left_in, top_ff, top_in;
   logic signed [COORD_BITS-1:0] right_ff, right_in, bottom_ff, bottom_in;
   logic erase_ff, erase_in;

   logic found_ff, found_in, full_ff, full_in;
   logic signed [COORD_BITS-1:0] res_left_ff, res_left_in, res_top_ff, res_top_in;
   logic signed [COORD_BITS-1:0] res_right_ff, res_right_in;
   logic signed [COORD_BITS-1:0] res_bottom_ff, res_bottom_in;
   logic res_erase_ff, res_erase_in;

   logic wr_en, rd_en, stop;
   logic [AW-1:0] wr_addr;
   logic [EW-1:0] wr_data, rd_data;
   match_type match;

   logic signed [COORD_BITS-1:0] s_left, s_top, s_right, s_bottom;

   assign s_left   = rd_data[L_LO +: COORD_BITS];
   assign s_top    = rd_data[T_LO +: COORD_BITS];
   assign s_right  = rd_data[R_LO +: COORD_BITS];
   assign s_bottom = rd_data[B_LO +: COORD_BITS];

   drst_slot_mem #(
      .DEPTH (SLOT_COUNT),
      .WIDTH (EW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (issue_addr_ff),
      .rd_data (rd_data)
   );

   drst_slot_match #(
      .OWNER_BITS (OWNER_BITS),
      .COORD_BITS (COORD_BITS)
   ) u_match (
      .slot_used   (rd_data[U_BIT]),
      .slot_owner  (rd_data[O_LO +: OWNER_BITS]),
      .slot_left   (s_left),
      .slot_top    (s_top),
      .slot_right  (s_right),
      .slot_bottom (s_bottom),
      .req_owner   (owner_ff),
      .req_left    (left_ff),
      .req_top     (top_ff),
      .req_right   (right_ff),
      .req_bottom  (bottom_ff),
      .match       (match)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         issue_addr_ff <= '0;
         issue_on_ff   <= 1'b0;
         chk_on_ff     <= 1'b0;
      end else begin
         state_ff      <= state_in;
         issue_addr_ff <= issue_addr_in;
         issue_on_ff   <= issue_on_in;
         chk_on_ff     <= chk_on_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_addr_ff   <= chk_addr_in;
      op_ff         <= op_in;
      owner_ff      <= owner_in;
      left_ff       <= left_in;
      top_ff        <= top_in;
      right_ff      <= right_in;
      bottom_ff     <= bottom_in;
      erase_ff      <= erase_in;
      found_ff      <= found_in;
      full_ff       <= full_in;
      res_left_ff   <= res_left_in;
      res_top_ff    <= res_top_in;
      res_right_ff  <= res_right_in;
      res_bottom_ff <= res_bottom_in;
      res_erase_ff  <= res_erase_in;
   end

   always_comb begin
      state_in      = state_ff;
      issue_addr_in = issue_addr_ff;
      issue_on_in   = issue_on_ff;
      chk_on_in     = chk_on_ff;
      chk_addr_in   = chk_addr_ff;
      op_in         = op_ff;
      owner_in      = owner_ff;
      left_in       = left_ff;
      top_in        = top_ff;
      right_in      = right_ff;
      bottom_in     = bottom_ff;
      erase_in      = erase_ff;
      found_in      = found_ff;
      full_in       = full_ff;
      res_left_in   = res_left_ff;
      res_top_in    = res_top_ff;
      res_right_in  = res_right_ff;
      res_bottom_in = res_bottom_ff;
      res_erase_in  = res_erase_ff;
      wr_en         = 1'b0;
      wr_addr       = chk_addr_ff;
      wr_data       = rd_data;
      wr_data[U_BIT] = 1'b0;
      rd_en         = 1'b0;
      stop          = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = issue_addr_ff;
            wr_data = '0;
            if (issue_addr_ff == LAST) begin
               issue_addr_in = '0;
               state_in      = ST_IDLE;
            end else begin
               issue_addr_in = issue_addr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (start) begin
               op_in         = opcode_type'(req_opcode);
               owner_in      = req_owner;
               left_in       = req_rect_left;
               top_in        = req_rect_top;
               right_in      = req_rect_right;
               bottom_in     = req_rect_bottom;
               erase_in      = req_erase_in;
               found_in      = 1'b0;
               full_in       = 1'b0;
               res_left_in   = '0;
               res_top_in    = '0;
               res_right_in  = '0;
               res_bottom_in = '0;
               res_erase_in  = 1'b0;
               issue_addr_in = '0;
               issue_on_in   = 1'b1;
               chk_on_in     = 1'b0;
               state_in      = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_en       = issue_on_ff;
            chk_on_in   = issue_on_ff;
            chk_addr_in = issue_addr_ff;
            if (issue_on_ff) begin
               if (issue_addr_ff == LAST) begin
                  issue_on_in = 1'b0;
               end else begin
                  issue_addr_in = issue_addr_ff + 1'b1;
               end
            end
            if (chk_on_ff) begin
               case (op_ff)
                  OP_ADD: begin
                     if (match.free) begin
                        wr_en   = 1'b1;
                        wr_data = {1'b1, erase_ff, owner_ff, left_ff, top_ff,
                                   right_ff, bottom_ff};
                        stop    = 1'b1;
                     end else if (chk_addr_ff == LAST) begin
                        full_in = 1'b1;
                     end
                  end
                  OP_VALIDATE: begin
                     if (match.owner_hit && match.overlap) begin
                        wr_en    = 1'b1;
                        found_in = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     if (match.owner_hit) begin
                        wr_en    = 1'b1;
                        found_in = 1'b1;
                     end
                  end
                  OP_TAKE, OP_PEEK: begin
                     if (match.owner_hit) begin
                        wr_en         = (op_ff == OP_TAKE);
                        found_in      = 1'b1;
                        res_left_in   = s_left;
                        res_top_in    = s_top;
                        res_right_in  = s_right;
                        res_bottom_in = s_bottom;
                        res_erase_in  = rd_data[E_BIT];
                        stop          = 1'b1;
                     end else if (op_ff == OP_TAKE && chk_addr_ff == LAST) begin
                        // no slot of this owner: echo the request rectangle
                        res_left_in   = left_ff;
                        res_top_in    = top_ff;
                        res_right_in  = right_ff;
                        res_bottom_in = bottom_ff;
                     end
                  end
                  OP_QUERY: begin
                     if (match.owner_hit) begin
                        found_in = 1'b1;
                        stop     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (stop || chk_addr_ff == LAST) begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_RESP: begin
            issue_on_in = 1'b0;
            chk_on_in   = 1'b0;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = (state_ff == ST_RESP);
   assign rsp_found      = found_ff;
   assign rsp_table_full = full_ff;
   assign rsp_out_left   = res_left_ff;
   assign rsp_out_top    = res_top_ff;
   assign rsp_out_right  = res_right_ff;
   assign rsp_out_bottom = res_bottom_ff;
   assign rsp_erase_out  = res_erase_ff;

endmodule
